### rtl/keyframe_curve_evaluator_top_defines.svh
// Assertion macros shared by the keyframe curve evaluator RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef KEYFRAME_CURVE_EVALUATOR_TOP_DEFINES_SVH
`define KEYFRAME_CURVE_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication
`define KCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define KCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/kce_pkg.sv
// Package of the keyframe curve evaluator: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package kce_pkg;
    localparam int MAX_KEYS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int U_BITS    = 30;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int MODE_W    = 2;
    localparam int CNT_OUT_W = 5;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_CW    = $clog2(U_BITS);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0]       key_time;
        logic signed [VAL_W-1:0] key_value;
        logic signed [VAL_W-1:0] in_tangent;
        logic signed [VAL_W-1:0] out_tangent;
        logic [MODE_W-1:0]       interp;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef struct packed {
        logic                    is_sample;
        logic [TIME_W-1:0]       time_req;
        logic signed [VAL_W-1:0] key_value;
        logic signed [VAL_W-1:0] in_tangent;
        logic signed [VAL_W-1:0] out_tangent;
        logic [MODE_W-1:0]       interpolation;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_if;
endpackage
`default_nettype wire

### rtl/kce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/kce_front.sv
// Front end: accepts request items, classifies them and queues them.
// Depends on kce_pkg.
`default_nettype none
module kce_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             i_opcode,
    input  wire logic [kce_pkg::TIME_W-1:0]       i_time_req,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_key_value,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_in_tangent,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_out_tangent,
    input  wire logic [kce_pkg::MODE_W-1:0]       i_interpolation,
    output kce_pkg::t_cmd_if                      o_cmd,
    input  wire logic                             i_take
);
    import kce_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    logic       w_push_ok, w_take_ok;
    t_cmd       w_new;

    assign full      = (r_fill == 2'd2);
    assign w_push_ok = push && !full;
    assign w_take_ok = i_take && (r_fill != 2'd0);

    always_comb begin
        w_new.is_sample     = (i_opcode == OP_SAMPLE);
        w_new.time_req      = i_time_req;
        w_new.key_value     = i_key_value;
        w_new.in_tangent    = i_in_tangent;
        w_new.out_tangent   = i_out_tangent;
        w_new.interpolation = i_interpolation;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push_ok;
        n_rd_ptr = r_rd_ptr ^ w_take_ok;
        n_fill   = r_fill + {1'b0, w_push_ok} - {1'b0, w_take_ok};
    end

    assign o_cmd.valid = (r_fill != 2'd0);
    assign o_cmd.cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= w_new;
        end
    end
endmodule
`default_nettype wire

### rtl/kce_back.sv
// Back end: key table search, sorted insert, divide and interpolation sequencer.
// Depends on kce_pkg, kce_ram and the assertion macro header.
`default_nettype none
`include "keyframe_curve_evaluator_top_defines.svh"
module kce_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire kce_pkg::t_cmd_if                 i_cmd,
    output logic                                  o_take,
    input  wire logic                             pop,
    output logic                                  empty,
    output logic signed [kce_pkg::VAL_W-1:0]      o_sample_value,
    output logic                                  o_status,
    output logic [kce_pkg::CNT_OUT_W-1:0]         o_stored_keys
);
    import kce_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_EV   = 4'd2;
    localparam logic [3:0] S_INS  = 4'd3;
    localparam logic [3:0] S_SHRD = 4'd4;
    localparam logic [3:0] S_SHWR = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_PREP = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;

    localparam logic signed [MUL_W-1:0]  U_ONE  = MUL_W'(1) << U_BITS;
    localparam logic signed [PROD_W-1:0] U_HALF = PROD_W'(1) << (U_BITS - 1);
    localparam logic signed [PROD_W-1:0] F_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sd2147483648);

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [VAL_W-1:0] y;
        if (x > SAT_HI) begin
            y = 32'sh7FFFFFFF;
        end else if (x < SAT_LO) begin
            y = 32'sh80000000;
        end else begin
            y = x[VAL_W-1:0];
        end
        return y;
    endfunction

    logic [3:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic                    r_eq, n_eq;
    t_cmd                    r_cmd, n_cmd;
    t_key                    r_left, n_left;
    t_key                    r_right, n_right;
    logic [TIME_W-1:0]       r_d, n_d;
    logic [TIME_W-1:0]       r_rem, n_rem;
    logic [DIV_CW-1:0]       r_dcnt, n_dcnt;
    logic [U_BITS-1:0]       r_u, n_u;
    logic [U_BITS-1:0]       r_u2, n_u2;
    logic signed [MUL_W-1:0] r_h00, n_h00, r_h01, n_h01, r_h10, n_h10, r_g11, n_g11;
    logic signed [MUL_W-1:0] r_w10, n_w10, r_w11, n_w11;
    logic signed [PROD_W-1:0] r_prod, n_prod, r_acc, n_acc;
    logic [2:0]              r_step, n_step;
    logic                    r_res_valid, n_res_valid;
    logic signed [VAL_W-1:0] r_res_value, n_res_value;
    logic                    r_res_status, n_res_status;
    logic [CNT_OUT_W-1:0]    r_res_count, n_res_count;

    logic                    w_we;
    logic [KEY_AW-1:0]       w_waddr, w_raddr;
    logic [KEY_W-1:0]        w_wdata, w_rdata;
    t_key                    w_rkey, w_nkey;
    logic                    w_linear;
    logic signed [MUL_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;

    logic [TIME_W:0]          c_rem2;
    logic                     c_ge;
    logic [CNT_W-1:0]         c_idx_dn;
    logic signed [MUL_W-1:0]  c_u, c_u2, c_u3, c_h10, c_g11;
    logic signed [PROD_W-1:0] c_rnd, c_sum, c_fin;

    kce_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rkey   = t_key'(w_rdata);
    assign w_linear = (r_left.interp == MODE_LINEAR);
    assign c_idx_dn = r_idx - CNT_W'(1);
    assign w_raddr  = (r_state == S_SHRD) ? c_idx_dn[KEY_AW-1:0] : r_idx[KEY_AW-1:0];

    always_comb begin
        w_nkey.key_time    = r_cmd.time_req;
        w_nkey.key_value   = r_cmd.key_value;
        w_nkey.in_tangent  = r_cmd.in_tangent;
        w_nkey.out_tangent = r_cmd.out_tangent;
        w_nkey.interp      = r_cmd.interpolation;
    end

    always_comb begin
        w_ma = MUL_W'(r_u);
        w_mb = MUL_W'(r_u);
        if (w_linear) begin
            w_ma = MUL_W'(r_right.key_value) - MUL_W'(r_left.key_value);
        end else begin
            case (r_step)
                3'd0: w_ma = MUL_W'(r_u);
                3'd1: w_ma = MUL_W'(r_u2);
                3'd2: begin w_ma = r_h10; w_mb = MUL_W'(r_d); end
                3'd3: begin w_ma = r_g11; w_mb = MUL_W'(r_d); end
                3'd4: begin w_ma = r_h00; w_mb = MUL_W'(r_left.key_value); end
                3'd5: begin w_ma = r_h01; w_mb = MUL_W'(r_right.key_value); end
                3'd6: begin w_ma = r_w10; w_mb = MUL_W'(r_left.out_tangent); end
                default: begin w_ma = r_w11; w_mb = MUL_W'(r_right.in_tangent); end
            endcase
        end
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        c_rem2 = {r_rem, 1'b0};
        c_ge   = (c_rem2 >= {1'b0, r_d});
        c_u    = MUL_W'(r_u);
        c_u2   = MUL_W'(r_u2);
        c_u3   = MUL_W'(r_prod[U_BITS +: U_BITS]);
        c_h10  = c_u3 - (c_u2 <<< 1) + c_u;
        c_g11  = c_u2 - c_u3;
        c_rnd  = r_prod + U_HALF;
        c_sum  = r_acc + r_prod;
        c_fin  = (r_acc - r_prod + F_HALF) >>> FRAC_BITS;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_eq         = r_eq;
        n_cmd        = r_cmd;
        n_left       = r_left;
        n_right      = r_right;
        n_d          = r_d;
        n_rem        = r_rem;
        n_dcnt       = r_dcnt;
        n_u          = r_u;
        n_u2         = r_u2;
        n_h00        = r_h00;
        n_h01        = r_h01;
        n_h10        = r_h10;
        n_g11        = r_g11;
        n_w10        = r_w10;
        n_w11        = r_w11;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_step       = r_step;
        n_res_valid  = r_res_valid && !pop;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        o_take       = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_pos[KEY_AW-1:0];
        w_wdata      = w_nkey;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && !r_res_valid) begin
                    o_take = 1'b1;
                    n_cmd  = i_cmd.cmd;
                    n_idx  = '0;
                    if (r_count != '0) begin
                        n_state = S_RD;
                    end else if (i_cmd.cmd.is_sample) begin
                        n_res_valid  = 1'b1;
                        n_res_value  = '0;
                        n_res_status = 1'b0;
                        n_res_count  = CNT_OUT_W'(r_count);
                    end else begin
                        n_pos   = '0;
                        n_eq    = 1'b0;
                        n_state = S_INS;
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_count) begin
                    if (r_cmd.is_sample) begin
                        n_res_valid  = 1'b1;
                        n_res_value  = r_left.key_value;
                        n_res_status = 1'b0;
                        n_res_count  = CNT_OUT_W'(r_count);
                        n_state      = S_IDLE;
                    end else begin
                        n_pos   = r_count;
                        n_eq    = 1'b0;
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (!r_cmd.is_sample) begin
                    if (w_rkey.key_time >= r_cmd.time_req) begin
                        n_pos   = r_idx;
                        n_eq    = (w_rkey.key_time == r_cmd.time_req);
                        n_state = S_INS;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_RD;
                    end
                end else if (r_idx == '0 && r_cmd.time_req <= w_rkey.key_time) begin
                    n_res_valid  = 1'b1;
                    n_res_value  = w_rkey.key_value;
                    n_res_status = 1'b0;
                    n_res_count  = CNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end else if (w_rkey.key_time > r_cmd.time_req) begin
                    n_right = w_rkey;
                    n_state = S_PREP;
                end else begin
                    n_left  = w_rkey;
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_INS: begin
                if (r_eq) begin
                    n_state = S_WR;
                end else if (r_count == CNT_W'(MAX_KEYS)) begin
                    n_res_valid  = 1'b1;
                    n_res_value  = '0;
                    n_res_status = 1'b1;
                    n_res_count  = CNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_count;
                    n_state = (r_count == r_pos) ? S_WR : S_SHRD;
                end
            end
            S_SHRD: begin
                n_state = S_SHWR;
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[KEY_AW-1:0];
                w_wdata = w_rdata;
                n_idx   = c_idx_dn;
                n_state = (c_idx_dn == r_pos) ? S_WR : S_SHRD;
            end
            S_WR: begin
                w_we = 1'b1;
                if (!r_eq) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_res_valid  = 1'b1;
                n_res_value  = '0;
                n_res_status = 1'b0;
                n_res_count  = CNT_OUT_W'(n_count);
                n_state      = S_IDLE;
            end
            S_PREP: begin
                n_d = r_right.key_time - r_left.key_time;
                if (r_left.interp == MODE_STEP || n_d == '0) begin
                    n_res_valid  = 1'b1;
                    n_res_value  = r_left.key_value;
                    n_res_status = 1'b0;
                    n_res_count  = CNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end else begin
                    n_rem   = r_cmd.time_req - r_left.key_time;
                    n_u     = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = c_ge ? TIME_W'(c_rem2 - {1'b0, r_d}) : c_rem2[TIME_W-1:0];
                n_u    = {r_u[U_BITS-2:0], c_ge};
                n_dcnt = r_dcnt + DIV_CW'(1);
                if (r_dcnt == DIV_CW'(U_BITS - 1)) begin
                    n_step  = 3'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = w_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_MUL;
                n_step  = r_step + 3'd1;
                if (w_linear) begin
                    n_res_valid  = 1'b1;
                    n_res_value  = sat32((c_rnd >>> U_BITS) + PROD_W'(r_left.key_value));
                    n_res_status = 1'b0;
                    n_res_count  = CNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end else begin
                    case (r_step)
                        3'd0: n_u2 = r_prod[U_BITS +: U_BITS];
                        3'd1: begin
                            n_h00 = (c_u3 <<< 1) - c_u2 - (c_u2 <<< 1) + U_ONE;
                            n_h01 = c_u2 + (c_u2 <<< 1) - (c_u3 <<< 1);
                            n_h10 = c_h10[MUL_W-1] ? '0 : c_h10;
                            n_g11 = c_g11[MUL_W-1] ? '0 : c_g11;
                        end
                        3'd2: n_w10 = $signed(c_rnd[U_BITS +: MUL_W]);
                        3'd3: n_w11 = $signed(c_rnd[U_BITS +: MUL_W]);
                        3'd4: n_acc = r_prod;
                        3'd5: n_acc = c_sum >>> (U_BITS - FRAC_BITS);
                        3'd6: n_acc = c_sum;
                        default: begin
                            n_res_valid  = 1'b1;
                            n_res_value  = sat32(c_fin);
                            n_res_status = 1'b0;
                            n_res_count  = CNT_OUT_W'(r_count);
                            n_state      = S_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_eq         <= n_eq;
        r_cmd        <= n_cmd;
        r_left       <= n_left;
        r_right      <= n_right;
        r_d          <= n_d;
        r_rem        <= n_rem;
        r_dcnt       <= n_dcnt;
        r_u          <= n_u;
        r_u2         <= n_u2;
        r_h00        <= n_h00;
        r_h01        <= n_h01;
        r_h10        <= n_h10;
        r_g11        <= n_g11;
        r_w10        <= n_w10;
        r_w11        <= n_w11;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_step       <= n_step;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
    end

    assign empty          = !r_res_valid;
    assign o_sample_value = r_res_value;
    assign o_status       = r_res_status;
    assign o_stored_keys  = r_res_count;

    `KCE_ASSERT_IMPL(a_cnt_step, r_count != $past(r_count), r_count == $past(r_count) + 1'b1)
    `KCE_ASSERT_IMPL(a_cnt_max, 1'b1, r_count <= CNT_W'(MAX_KEYS))
    `KCE_ASSERT_IMPL(a_shift_above_pos, r_state == S_SHWR, r_idx > r_pos)
    `KCE_ASSERT_NEXT(a_full_drop, r_state == S_INS && !r_eq && r_count == CNT_W'(MAX_KEYS),
                     r_res_valid && r_res_status)
endmodule
`default_nettype wire

### rtl/keyframe_curve_evaluator_top.sv
// An add reads and compares table entries in turn, then shifts the later entries up and writes the key.
// A sample reads entries the same way, then runs the bit-serial divide and the multiply and accumulate steps.
// One item is in the back end at a time; a two-entry request queue takes items meanwhile.
// The scan and shift rate is set by the registered read of the key RAM, the sample by the divider.
// Reset (synchronous, active low) empties the key table count, request queue and result register.
`default_nettype none
module keyframe_curve_evaluator_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             i_opcode,
    input  wire logic [kce_pkg::TIME_W-1:0]       i_time_req,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_key_value,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_in_tangent,
    input  wire logic signed [kce_pkg::VAL_W-1:0] i_out_tangent,
    input  wire logic [kce_pkg::MODE_W-1:0]       i_interpolation,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic signed [kce_pkg::VAL_W-1:0]      o_sample_value,
    output logic                                  o_status,
    output logic [kce_pkg::CNT_OUT_W-1:0]         o_stored_keys
);
    import kce_pkg::*;

    t_cmd_if w_cmd;
    logic    w_take;

    kce_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_time_req      (i_time_req),
        .i_key_value     (i_key_value),
        .i_in_tangent    (i_in_tangent),
        .i_out_tangent   (i_out_tangent),
        .i_interpolation (i_interpolation),
        .o_cmd           (w_cmd),
        .i_take          (w_take)
    );

    kce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_take         (w_take),
        .pop            (pop),
        .empty          (empty),
        .o_sample_value (o_sample_value),
        .o_status       (o_status),
        .o_stored_keys  (o_stored_keys)
    );
endmodule
`default_nettype wire

### verif/keyframe_curve_evaluator_top_test.sv
// Testbench for keyframe_curve_evaluator_top: directed and random add and sample requests
// checked against a scoreboard that keeps its own sorted key table. Depends on kce_pkg.
// Needs only the RTL of the block.
`default_nettype none

class kce_scoreboard;
    typedef struct {
        logic signed [31:0] value;
        logic               status;
        logic [4:0]         keys;
    } t_result;

    logic [31:0]        tbl_time [kce_pkg::MAX_KEYS];
    logic signed [31:0] tbl_value[kce_pkg::MAX_KEYS];
    logic signed [31:0] tbl_tin  [kce_pkg::MAX_KEYS];
    logic signed [31:0] tbl_tout [kce_pkg::MAX_KEYS];
    logic [1:0]         tbl_mode [kce_pkg::MAX_KEYS];
    int                 tbl_count;
    t_result            pending_results[$];
    int                 errors;
    int                 n_adds;
    int                 n_samples;
    int                 n_dropped;
    int                 n_checked;

    function new();
        tbl_count = 0;
        errors    = 0;
        n_adds    = 0;
        n_samples = 0;
        n_dropped = 0;
        n_checked = 0;
    endfunction

    function longint sat_value(longint x);
        if (x > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
        if (x < longint'(32'sh80000000)) return longint'(32'sh80000000);
        return x;
    endfunction

    function longint round_up(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic signed [31:0] interpolate(logic [31:0] t);
        int                i;
        longint            vl, vr, su, su2, su3, h00, h01, h10, g11, a, b, w10s, w11s;
        longint unsigned   d, u, u2, u3, w10, w11, dt;
        logic [1:0]        mode;
        if (tbl_count == 0) return 0;
        if (t <= tbl_time[0]) return tbl_value[0];
        if (t >= tbl_time[tbl_count-1]) return tbl_value[tbl_count-1];
        i = 1;
        while (i < tbl_count - 1 && tbl_time[i] <= t) i++;
        vl   = tbl_value[i-1];
        vr   = tbl_value[i];
        mode = tbl_mode[i-1];
        if (mode == kce_pkg::MODE_STEP) return vl[31:0];
        d  = tbl_time[i] - tbl_time[i-1];
        if (d == 0) return vl[31:0];
        dt = t - tbl_time[i-1];
        u  = (dt << kce_pkg::U_BITS) / d;
        su = longint'(u);
        if (mode == kce_pkg::MODE_LINEAR)
            return sat_value(vl + round_up((vr - vl) * su, kce_pkg::U_BITS));
        u2  = (u * u) >> kce_pkg::U_BITS;
        u3  = (u2 * u) >> kce_pkg::U_BITS;
        su2 = longint'(u2);
        su3 = longint'(u3);
        h00 = 2 * su3 - 3 * su2 + (longint'(1) << kce_pkg::U_BITS);
        h01 = 3 * su2 - 2 * su3;
        h10 = su3 - 2 * su2 + su;
        g11 = su2 - su3;
        if (h10 < 0) h10 = 0;
        if (g11 < 0) g11 = 0;
        w10  = (longint'(h10) * d + (64'd1 << (kce_pkg::U_BITS - 1))) >> kce_pkg::U_BITS;
        w11  = (longint'(g11) * d + (64'd1 << (kce_pkg::U_BITS - 1))) >> kce_pkg::U_BITS;
        w10s = longint'(w10);
        w11s = longint'(w11);
        a = (h00 * vl + h01 * vr) >>> (kce_pkg::U_BITS - kce_pkg::FRAC_BITS);
        b = w10s * longint'(tbl_tout[i-1]) - w11s * longint'(tbl_tin[i]);
        return sat_value(round_up(a + b, kce_pkg::FRAC_BITS));
    endfunction

    function logic insert_key(kce_pkg::t_cmd c);
        int i;
        int j;
        i = 0;
        while (i < tbl_count && tbl_time[i] < c.time_req) i++;
        if (!(i < tbl_count && tbl_time[i] == c.time_req)) begin
            if (tbl_count >= kce_pkg::MAX_KEYS) return 1'b1;
            for (j = tbl_count; j > i; j--) begin
                tbl_time[j]  = tbl_time[j-1];
                tbl_value[j] = tbl_value[j-1];
                tbl_tin[j]   = tbl_tin[j-1];
                tbl_tout[j]  = tbl_tout[j-1];
                tbl_mode[j]  = tbl_mode[j-1];
            end
            tbl_count++;
        end
        tbl_time[i]  = c.time_req;
        tbl_value[i] = c.key_value;
        tbl_tin[i]   = c.in_tangent;
        tbl_tout[i]  = c.out_tangent;
        tbl_mode[i]  = c.interpolation;
        return 1'b0;
    endfunction

    function void note_request(kce_pkg::t_cmd c);
        t_result r;
        r.value  = 0;
        r.status = 1'b0;
        if (c.is_sample == kce_pkg::OP_SAMPLE) begin
            r.value = interpolate(c.time_req);
            n_samples++;
        end else begin
            r.status = insert_key(c);
            n_adds++;
            if (r.status) n_dropped++;
        end
        r.keys = tbl_count[4:0];
        pending_results = {pending_results, r};
    endfunction

    function void check_result(logic signed [31:0] value, logic status, logic [4:0] keys);
        t_result r;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: value %h status %b keys %0d",
                     $time, value, status, keys);
            errors++;
            return;
        end
        r = pending_results.pop_front();
        n_checked++;
        if (value !== r.value) begin
            $display("%0t: sample_value expected %h actual %h", $time, r.value, value);
            errors++;
        end
        if (status !== r.status) begin
            $display("%0t: status expected %b actual %b", $time, r.status, status);
            errors++;
        end
        if (keys !== r.keys) begin
            $display("%0t: stored_keys expected %0d actual %0d", $time, r.keys, keys);
            errors++;
        end
    endfunction
endclass

module keyframe_curve_evaluator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_opcode = 1'b0;
    logic [31:0]        i_time_req = '0;
    logic signed [31:0] i_key_value = '0;
    logic signed [31:0] i_in_tangent = '0;
    logic signed [31:0] i_out_tangent = '0;
    logic [1:0]         i_interpolation = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_sample_value;
    logic               o_status;
    logic [4:0]         o_stored_keys;

    kce_scoreboard  sb;
    kce_pkg::t_cmd  requests[$];
    logic [31:0]    key_pool[$];
    int             pop_mode = 0;
    int             pop_phase = 0;

    keyframe_curve_evaluator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_time_req     (i_time_req),
        .i_key_value    (i_key_value),
        .i_in_tangent   (i_in_tangent),
        .i_out_tangent  (i_out_tangent),
        .i_interpolation(i_interpolation),
        .empty          (empty),
        .pop            (pop),
        .o_sample_value (o_sample_value),
        .o_status       (o_status),
        .o_stored_keys  (o_stored_keys)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
        endcase
    endfunction

    function void queue_add(logic [31:0] t, logic [31:0] v, logic [31:0] tin,
                            logic [31:0] tout, logic [1:0] mode);
        kce_pkg::t_cmd c;
        c.is_sample     = kce_pkg::OP_ADD;
        c.time_req      = t;
        c.key_value     = v;
        c.in_tangent    = tin;
        c.out_tangent   = tout;
        c.interpolation = mode;
        requests = {requests, c};
    endfunction

    function void queue_sample(logic [31:0] t);
        kce_pkg::t_cmd c;
        c.is_sample     = kce_pkg::OP_SAMPLE;
        c.time_req      = t;
        c.key_value     = $urandom;
        c.in_tangent    = $urandom;
        c.out_tangent   = $urandom;
        c.interpolation = 2'($urandom_range(0, 3));
        requests = {requests, c};
    endfunction

    function void build_random(int n);
        logic [31:0]     t;
        logic [31:0]     lo;
        logic [31:0]     hi;
        longint unsigned span;
        bit              known;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 40) begin
                if (key_pool.size() > 0 && $urandom_range(0, 99) < 35)
                    t = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else if (key_pool.size() > 0 && $urandom_range(0, 1) == 0)
                    t = key_pool[$urandom_range(0, key_pool.size() - 1)]
                        + $urandom_range(0, 64) - 32;
                else
                    t = $urandom;
                known = 1'b0;
                foreach (key_pool[j]) if (key_pool[j] == t) known = 1'b1;
                if (!known && key_pool.size() < kce_pkg::MAX_KEYS) key_pool = {key_pool, t};
                queue_add(t, pick_value(), pick_value(), pick_value(),
                          2'($urandom_range(0, 3)));
            end else if (key_pool.size() > 0 && $urandom_range(0, 99) < 70) begin
                lo = key_pool[$urandom_range(0, key_pool.size() - 1)];
                hi = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if (lo > hi) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                span = longint'(hi - lo) + 1;
                queue_sample(lo + 32'(({$urandom, $urandom}) % span));
            end else begin
                queue_sample($urandom);
            end
        end
    endfunction

    task automatic send_request(kce_pkg::t_cmd c);
        push            <= 1'b1;
        i_opcode        <= c.is_sample;
        i_time_req      <= c.time_req;
        i_key_value     <= c.key_value;
        i_in_tangent    <= c.in_tangent;
        i_out_tangent   <= c.out_tangent;
        i_interpolation <= c.interpolation;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(c);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_sample_value, o_status, o_stored_keys);
        end
        pop_phase <= pop_phase + 1;
        if (pop_phase % 300 == 0) begin
            pop_mode <= $urandom_range(0, 3);
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((pop_phase % 37) > 20);
        endcase
    end

    initial begin
        #5ms;
        $display("keyframe_curve_evaluator_top verification failed");
        $finish;
    end

    initial begin
        int burst;
        int gap;
        int idx;
        sb = new();
        queue_sample(32'h0);
        queue_sample(32'hFFFFFFFF);
        queue_add(32'h00100000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 2'd2);
        queue_sample(32'h0);
        queue_sample(32'h00100000);
        queue_sample(32'hFFFFFFFF);
        queue_add(32'h00300000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 2'd3);
        queue_sample(32'h00200000);
        queue_add(32'h00100000, 32'h7FFFFFFF, 32'h0, 32'h0, kce_pkg::MODE_LINEAR);
        queue_sample(32'h00200000);
        queue_add(32'h00200000, 32'h0, 32'h00010000, 32'hFFFF0000, kce_pkg::MODE_STEP);
        queue_sample(32'h00280000);
        queue_add(32'hFFFFFFFF, 32'h12345678, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd2);
        queue_add(32'h00300000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd2);
        queue_sample(32'hFFFFFFFE);
        queue_sample(32'h00300001);
        queue_add(32'h0, 32'hFFFF0000, 32'h80000000, 32'h80000000, 2'd2);
        queue_sample(32'h1);
        queue_add(32'h1, 32'h00020000, 32'h0, 32'h0, kce_pkg::MODE_LINEAR);
        queue_sample(32'h1);
        queue_sample(32'h00080000);
        key_pool = '{32'h0, 32'h1, 32'h00100000, 32'h00200000, 32'h00300000, 32'hFFFFFFFF};
        build_random(1230);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx   = 0;
        burst = $urandom_range(1, 16);
        foreach (requests[k]) begin
            send_request(requests[k]);
            idx++;
            burst--;
            if (burst <= 0 && !(idx > 500 && idx < 700)) begin
                push <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge i_clk);
                burst = $urandom_range(1, 16);
            end
        end
        push <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.pending_results.size() != 0) sb.errors++;

        $display("covered %0d adds (%0d dropped on a full table) and %0d samples",
                 sb.n_adds, sb.n_dropped, sb.n_samples);
        $display("checked %0d results, %0d mismatches", sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("keyframe_curve_evaluator_top verification clean");
        end else begin
            $display("keyframe_curve_evaluator_top verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/kce_pkg.sv
rtl/kce_ram.sv
rtl/kce_front.sv
rtl/kce_back.sv
rtl/keyframe_curve_evaluator_top.sv
verif/keyframe_curve_evaluator_top_test.sv
